/* rtl/twb_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package twb_pkg;

  localparam int OP_W  = 33;
  localparam int ACC_W = 66;

  localparam int PWM_LIMIT_DEF       = 8300;
  localparam int YAW_RATE_OFFSET_DEF = 0;

  localparam logic signed [OP_W-1:0] SQRT3_Q30      = 33'sd1859775393;
  localparam logic signed [OP_W-1:0] HALF_SQRT3_Q30 = 33'sd929887697;
  localparam logic signed [OP_W-1:0] LPF_KEEP       = 33'sd2867;
  localparam logic signed [OP_W-1:0] LPF_TAKE       = 33'sd1229;
  localparam logic signed [OP_W-1:0] NEG_HALF_Q30   = -33'sd536870912;

  localparam logic signed [ACC_W-1:0] INT_CLAMP = 66'sd110592000;
  localparam logic signed [ACC_W-1:0] Z_LIMIT   = 66'sd524287;

  typedef enum logic [3:0] {
    REG_ROLL_TARGET  = 4'd0,
    REG_PITCH_TARGET = 4'd1,
    REG_SPEED_GAIN_P = 4'd2,
    REG_SPEED_GAIN_I = 4'd3,
    REG_TILT_GAIN_P  = 4'd4,
    REG_TILT_GAIN_D  = 4'd5,
    REG_SPIN_GAIN_P  = 4'd6,
    REG_SPIN_GAIN_D  = 4'd7
  } reg_idx_t;

  typedef struct packed {
    logic signed [14:0] roll_target;
    logic signed [14:0] pitch_target;
    logic [23:0]        speed_gain_p;
    logic [23:0]        speed_gain_i;
    logic [23:0]        tilt_gain_p;
    logic [23:0]        tilt_gain_d;
    logic [23:0]        spin_gain_p;
    logic [23:0]        spin_gain_d;
  } cfg_regs_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_SY,
    ST_FX1, ST_FX2, ST_IX, ST_VX1, ST_VX2, ST_BX1, ST_BX2, ST_MX,
    ST_FY1, ST_FY2, ST_IY, ST_VY1, ST_VY2, ST_BY1, ST_BY2, ST_MY,
    ST_Z1, ST_Z2, ST_Z3, ST_DA,
    ST_B1, ST_B2, ST_B3, ST_C1, ST_C2, ST_C3, ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    BASE_ZERO,
    BASE_ACC,
    BASE_EXT
  } base_sel_t;

  typedef struct packed {
    logic                     en;
    base_sel_t                base;
    logic signed [OP_W-1:0]   opa;
    logic signed [OP_W-1:0]   opb;
    logic signed [ACC_W-1:0]  ext;
  } mac_ctl_t;

  function automatic logic signed [ACC_W-1:0] tshift(input logic signed [ACC_W-1:0] v,
                                                     input int unsigned s);
    logic signed [ACC_W-1:0] bias;
    bias = v[ACC_W-1] ? ((66'sd1 <<< s) - 66'sd1) : 66'sd0;
    return (v + bias) >>> s;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -66'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [14:0] drive(input logic signed [ACC_W-1:0] v,
                                               input logic signed [15:0] lim);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    logic signed [ACC_W-1:0] r;
    hi = (66'(lim) > 66'sd16383) ? 66'sd16383 : 66'(lim);
    lo = (-66'(lim) < -66'sd16384) ? -66'sd16384 : -66'(lim);
    if (v > hi) begin
      r = hi;
    end else if (v < lo) begin
      r = lo;
    end else begin
      r = v;
    end
    return r[14:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/twb_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface twb_in_if;
  logic               valid;
  logic               ready;
  logic signed [14:0] roll_angle;
  logic signed [14:0] pitch_angle;
  logic signed [15:0] roll_rate;
  logic signed [15:0] pitch_rate;
  logic signed [15:0] yaw_rate;
  logic signed [15:0] wheel_count_a;
  logic signed [15:0] wheel_count_b;
  logic signed [15:0] wheel_count_c;
  logic               stop;
  modport source(output valid, roll_angle, pitch_angle, roll_rate, pitch_rate, yaw_rate,
                 wheel_count_a, wheel_count_b, wheel_count_c, stop, input ready);
  modport sink(input valid, roll_angle, pitch_angle, roll_rate, pitch_rate, yaw_rate,
               wheel_count_a, wheel_count_b, wheel_count_c, stop, output ready);
endinterface

interface twb_out_if;
  logic               valid;
  logic               ready;
  logic signed [14:0] drive_a;
  logic signed [14:0] drive_b;
  logic signed [14:0] drive_c;
  modport source(output valid, drive_a, drive_b, drive_c, input ready);
  modport sink(input valid, drive_a, drive_b, drive_c, output ready);
endinterface

interface twb_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [23:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/twb_cfg.sv */
`timescale 1ns / 1ps
`default_nettype none

module twb_cfg (
  input  wire               clk,
  input  wire               rst_n,
  twb_cfg_if.sink           cfg_wr,
  output twb_pkg::cfg_regs_t regs
);

  twb_pkg::cfg_regs_t regs_r;
  twb_pkg::cfg_regs_t regs_nxt;

  assign cfg_wr.ready = 1'b1;
  assign regs = regs_r;

  always_comb begin
    regs_nxt = regs_r;
    if (cfg_wr.valid) begin
      unique case (cfg_wr.index)
        twb_pkg::REG_ROLL_TARGET:  regs_nxt.roll_target  = cfg_wr.data[14:0];
        twb_pkg::REG_PITCH_TARGET: regs_nxt.pitch_target = cfg_wr.data[14:0];
        twb_pkg::REG_SPEED_GAIN_P: regs_nxt.speed_gain_p = cfg_wr.data;
        twb_pkg::REG_SPEED_GAIN_I: regs_nxt.speed_gain_i = cfg_wr.data;
        twb_pkg::REG_TILT_GAIN_P:  regs_nxt.tilt_gain_p  = cfg_wr.data;
        twb_pkg::REG_TILT_GAIN_D:  regs_nxt.tilt_gain_d  = cfg_wr.data;
        twb_pkg::REG_SPIN_GAIN_P:  regs_nxt.spin_gain_p  = cfg_wr.data;
        twb_pkg::REG_SPIN_GAIN_D:  regs_nxt.spin_gain_d  = cfg_wr.data;
        default:                   regs_nxt = regs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.roll_target  <= -15'sd288;
      regs_r.pitch_target <= 15'sd19;
      regs_r.speed_gain_p <= 24'd163840;
      regs_r.speed_gain_i <= 24'd123;
      regs_r.tilt_gain_p  <= 24'd3686400;
      regs_r.tilt_gain_d  <= 24'd634880;
      regs_r.spin_gain_p  <= 24'd40960;
      regs_r.spin_gain_d  <= 24'd4096;
    end else begin
      regs_r <= regs_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/twb_mac.sv */
`timescale 1ns / 1ps
`default_nettype none

module twb_mac (
  input  wire                                    clk,
  input  twb_pkg::mac_ctl_t                      ctl,
  output logic signed [twb_pkg::ACC_W-1:0]       acc
);

  logic signed [twb_pkg::ACC_W-1:0] acc_r;
  logic signed [twb_pkg::ACC_W-1:0] acc_nxt;
  logic signed [twb_pkg::ACC_W-1:0] base;

  always_comb begin
    unique case (ctl.base)
      twb_pkg::BASE_ACC: base = acc_r;
      twb_pkg::BASE_EXT: base = ctl.ext;
      default:           base = '0;
    endcase
    acc_nxt = base + ctl.opa * ctl.opb;
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

`default_nettype wire

/* rtl/three_wheel_balance_controller.sv */
`timescale 1ns / 1ps
`default_nettype none

// Balance controller for a three-wheel omni platform. One item is one control tick and
// yields one item of three saturated wheel drives. All products go through a single
// 33 by 33 bit multiply-accumulate unit stepped by a sequencer; a stop item skips the
// products and goes straight to the done state. The input is ready
// again once the result is loaded into the output register. Configuration writes are
// taken at any time and should be made while the block is idle.
module three_wheel_balance_controller #(
  parameter int PWM_LIMIT       = twb_pkg::PWM_LIMIT_DEF,
  parameter int YAW_RATE_OFFSET = twb_pkg::YAW_RATE_OFFSET_DEF
) (
  input  wire        clk,
  input  wire        rst_n,
  twb_in_if.sink     in_item,
  twb_out_if.source  out_item,
  twb_cfg_if.sink    cfg_wr
);

  localparam logic signed [15:0] LIM    = 16'(PWM_LIMIT);
  localparam logic signed [17:0] YAW_OFS = 18'(YAW_RATE_OFFSET);
  localparam int W = twb_pkg::ACC_W;

  twb_pkg::cfg_regs_t regs;
  twb_pkg::mac_ctl_t  ctl;
  logic signed [W-1:0] acc;

  twb_pkg::state_t state_r, state_nxt;

  logic signed [14:0] roll_r, pitch_r;
  logic signed [15:0] rr_r, pr_r, yr_r, wa_r, wb_r, wc_r;
  logic signed [31:0] fx_r, ix_r, fy_r, iy_r, mx_r, my_r;
  logic signed [15:0] prev_r;
  logic signed [17:0] sy_r;
  logic signed [47:0] tmp_r;
  logic signed [19:0] mz_r;
  logic signed [14:0] da_r, db_r, dc_r;
  logic signed [14:0] oa_r, ob_r, oc_r;
  logic               ovalid_r;

  logic               accept;
  logic               load_out;
  logic signed [17:0] sx_val;
  logic signed [16:0] wdiff;
  logic signed [15:0] e_roll, e_pitch;
  logic signed [17:0] rr_x4, pr_x4, yaw_d;
  logic signed [31:0] nf;
  logic signed [32:0] isum_x, isum_y;
  logic signed [W-1:0] zt;

  twb_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_wr (cfg_wr),
    .regs   (regs)
  );

  twb_mac u_mac (
    .clk (clk),
    .ctl (ctl),
    .acc (acc)
  );

  assign in_item.ready = (state_r == twb_pkg::ST_IDLE);
  assign accept = in_item.valid && in_item.ready;
  assign load_out = (state_r == twb_pkg::ST_DONE) && (!ovalid_r || out_item.ready);

  assign out_item.valid   = ovalid_r;
  assign out_item.drive_a = oa_r;
  assign out_item.drive_b = ob_r;
  assign out_item.drive_c = oc_r;

  assign sx_val  = 18'(wa_r) + 18'(wa_r) - 18'(wb_r) - 18'(wc_r);
  assign wdiff   = 17'(wb_r) - 17'(wc_r);
  assign e_roll  = 16'(roll_r) - 16'(regs.roll_target);
  assign e_pitch = 16'(pitch_r) - 16'(regs.pitch_target);
  assign rr_x4   = {rr_r, 2'b00};
  assign pr_x4   = {pr_r, 2'b00};
  assign yaw_d   = 18'(yr_r) - 18'(prev_r) + YAW_OFS;
  assign nf      = twb_pkg::sat32(acc);
  assign isum_x  = 33'(ix_r) + 33'(nf);
  assign isum_y  = 33'(iy_r) + 33'(nf);
  assign zt      = twb_pkg::tshift(acc, 16);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      twb_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = in_item.stop ? twb_pkg::ST_DONE : twb_pkg::ST_SY;
        end
      end
      twb_pkg::ST_SY:  state_nxt = twb_pkg::ST_FX1;
      twb_pkg::ST_FX1: state_nxt = twb_pkg::ST_FX2;
      twb_pkg::ST_FX2: state_nxt = twb_pkg::ST_IX;
      twb_pkg::ST_IX:  state_nxt = twb_pkg::ST_VX1;
      twb_pkg::ST_VX1: state_nxt = twb_pkg::ST_VX2;
      twb_pkg::ST_VX2: state_nxt = twb_pkg::ST_BX1;
      twb_pkg::ST_BX1: state_nxt = twb_pkg::ST_BX2;
      twb_pkg::ST_BX2: state_nxt = twb_pkg::ST_MX;
      twb_pkg::ST_MX:  state_nxt = twb_pkg::ST_FY1;
      twb_pkg::ST_FY1: state_nxt = twb_pkg::ST_FY2;
      twb_pkg::ST_FY2: state_nxt = twb_pkg::ST_IY;
      twb_pkg::ST_IY:  state_nxt = twb_pkg::ST_VY1;
      twb_pkg::ST_VY1: state_nxt = twb_pkg::ST_VY2;
      twb_pkg::ST_VY2: state_nxt = twb_pkg::ST_BY1;
      twb_pkg::ST_BY1: state_nxt = twb_pkg::ST_BY2;
      twb_pkg::ST_BY2: state_nxt = twb_pkg::ST_MY;
      twb_pkg::ST_MY:  state_nxt = twb_pkg::ST_Z1;
      twb_pkg::ST_Z1:  state_nxt = twb_pkg::ST_Z2;
      twb_pkg::ST_Z2:  state_nxt = twb_pkg::ST_Z3;
      twb_pkg::ST_Z3:  state_nxt = twb_pkg::ST_DA;
      twb_pkg::ST_DA:  state_nxt = twb_pkg::ST_B1;
      twb_pkg::ST_B1:  state_nxt = twb_pkg::ST_B2;
      twb_pkg::ST_B2:  state_nxt = twb_pkg::ST_B3;
      twb_pkg::ST_B3:  state_nxt = twb_pkg::ST_C1;
      twb_pkg::ST_C1:  state_nxt = twb_pkg::ST_C2;
      twb_pkg::ST_C2:  state_nxt = twb_pkg::ST_C3;
      twb_pkg::ST_C3:  state_nxt = twb_pkg::ST_DONE;
      twb_pkg::ST_DONE: begin
        if (load_out) begin
          state_nxt = twb_pkg::ST_IDLE;
        end
      end
      default: state_nxt = twb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl.en   = 1'b0;
    ctl.base = twb_pkg::BASE_ZERO;
    ctl.opa  = '0;
    ctl.opb  = '0;
    ctl.ext  = '0;
    unique case (state_r)
      twb_pkg::ST_SY: begin
        ctl.en  = 1'b1;
        ctl.opa = 33'(wdiff);
        ctl.opb = twb_pkg::SQRT3_Q30;
      end
      twb_pkg::ST_FX1: begin
        ctl.en  = 1'b1;
        ctl.opa = 33'(fx_r);
        ctl.opb = twb_pkg::LPF_KEEP;
      end
      twb_pkg::ST_FY1: begin
        ctl.en  = 1'b1;
        ctl.opa = 33'(fy_r);
        ctl.opb = twb_pkg::LPF_KEEP;
      end
      twb_pkg::ST_FX2, twb_pkg::ST_FY2: begin
        ctl.en   = 1'b1;
        ctl.base = twb_pkg::BASE_EXT;
        ctl.ext  = twb_pkg::tshift(acc, 12);
        ctl.opa  = (state_r == twb_pkg::ST_FX2) ? 33'(sx_val) : 33'(sy_r);
        ctl.opb  = twb_pkg::LPF_TAKE;
      end
      twb_pkg::ST_VX1: begin
        ctl.en  = 1'b1;
        ctl.opa = 33'(fx_r);
        ctl.opb = $signed({9'd0, regs.speed_gain_p});
      end
      twb_pkg::ST_VY1: begin
        ctl.en  = 1'b1;
        ctl.opa = 33'(fy_r);
        ctl.opb = $signed({9'd0, regs.speed_gain_p});
      end
      twb_pkg::ST_VX2: begin
        ctl.en   = 1'b1;
        ctl.base = twb_pkg::BASE_ACC;
        ctl.opa  = 33'(ix_r);
        ctl.opb  = $signed({9'd0, regs.speed_gain_i});
      end
      twb_pkg::ST_VY2: begin
        ctl.en   = 1'b1;
        ctl.base = twb_pkg::BASE_ACC;
        ctl.opa  = 33'(iy_r);
        ctl.opb  = $signed({9'd0, regs.speed_gain_i});
      end
      twb_pkg::ST_BX1: begin
        ctl.en  = 1'b1;
        ctl.opa = 33'(e_roll);
        ctl.opb = $signed({9'd0, regs.tilt_gain_p});
      end
      twb_pkg::ST_BY1: begin
        ctl.en  = 1'b1;
        ctl.opa = 33'(e_pitch);
        ctl.opb = $signed({9'd0, regs.tilt_gain_p});
      end
      twb_pkg::ST_BX2: begin
        ctl.en   = 1'b1;
        ctl.base = twb_pkg::BASE_ACC;
        ctl.opa  = 33'(rr_x4);
        ctl.opb  = $signed({9'd0, regs.tilt_gain_d});
      end
      twb_pkg::ST_BY2: begin
        ctl.en   = 1'b1;
        ctl.base = twb_pkg::BASE_ACC;
        ctl.opa  = 33'(pr_x4);
        ctl.opb  = $signed({9'd0, regs.tilt_gain_d});
      end
      twb_pkg::ST_Z1: begin
        ctl.en  = 1'b1;
        ctl.opa = 33'(yr_r);
        ctl.opb = $signed({9'd0, regs.spin_gain_p});
      end
      twb_pkg::ST_Z2: begin
        ctl.en   = 1'b1;
        ctl.base = twb_pkg::BASE_ACC;
        ctl.opa  = 33'(yaw_d);
        ctl.opb  = $signed({9'd0, regs.spin_gain_d});
      end
      twb_pkg::ST_B1, twb_pkg::ST_C1: begin
        ctl.en   = 1'b1;
        ctl.base = twb_pkg::BASE_EXT;
        ctl.ext  = 66'(mz_r) <<< 42;
        ctl.opa  = 33'(mx_r);
        ctl.opb  = twb_pkg::NEG_HALF_Q30;
      end
      twb_pkg::ST_B2: begin
        ctl.en   = 1'b1;
        ctl.base = twb_pkg::BASE_ACC;
        ctl.opa  = 33'(my_r);
        ctl.opb  = twb_pkg::HALF_SQRT3_Q30;
      end
      twb_pkg::ST_C2: begin
        ctl.en   = 1'b1;
        ctl.base = twb_pkg::BASE_ACC;
        ctl.opa  = 33'(my_r);
        ctl.opb  = -twb_pkg::HALF_SQRT3_Q30;
      end
      default: ctl.en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= twb_pkg::ST_IDLE;
      ovalid_r <= 1'b0;
      fx_r     <= '0;
      ix_r     <= '0;
      fy_r     <= '0;
      iy_r     <= '0;
      prev_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        ovalid_r <= 1'b1;
      end else if (out_item.ready) begin
        ovalid_r <= 1'b0;
      end
      if (accept && in_item.stop) begin
        fx_r   <= '0;
        ix_r   <= '0;
        fy_r   <= '0;
        iy_r   <= '0;
        prev_r <= in_item.yaw_rate;
      end
      if (state_r == twb_pkg::ST_IX) begin
        fx_r <= nf;
        if (isum_x > 33'(twb_pkg::INT_CLAMP)) begin
          ix_r <= 32'(twb_pkg::INT_CLAMP);
        end else if (isum_x < -33'(twb_pkg::INT_CLAMP)) begin
          ix_r <= -32'(twb_pkg::INT_CLAMP);
        end else begin
          ix_r <= isum_x[31:0];
        end
      end
      if (state_r == twb_pkg::ST_IY) begin
        fy_r <= nf;
        if (isum_y > 33'(twb_pkg::INT_CLAMP)) begin
          iy_r <= 32'(twb_pkg::INT_CLAMP);
        end else if (isum_y < -33'(twb_pkg::INT_CLAMP)) begin
          iy_r <= -32'(twb_pkg::INT_CLAMP);
        end else begin
          iy_r <= isum_y[31:0];
        end
      end
      if (state_r == twb_pkg::ST_Z3) begin
        prev_r <= yr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      roll_r  <= in_item.roll_angle;
      pitch_r <= in_item.pitch_angle;
      rr_r    <= in_item.roll_rate;
      pr_r    <= in_item.pitch_rate;
      yr_r    <= in_item.yaw_rate;
      wa_r    <= in_item.wheel_count_a;
      wb_r    <= in_item.wheel_count_b;
      wc_r    <= in_item.wheel_count_c;
      da_r    <= '0;
      db_r    <= '0;
      dc_r    <= '0;
    end
    unique case (state_r)
      twb_pkg::ST_FX1: sy_r <= 18'(twb_pkg::tshift(acc, 30));
      twb_pkg::ST_BX1, twb_pkg::ST_BY1: tmp_r <= 48'(twb_pkg::tshift(acc, 12));
      twb_pkg::ST_MX: mx_r <= twb_pkg::sat32(66'(tmp_r) - twb_pkg::tshift(acc, 6));
      twb_pkg::ST_MY: my_r <= twb_pkg::sat32(66'(tmp_r) + twb_pkg::tshift(acc, 6));
      twb_pkg::ST_Z3: begin
        if (zt > twb_pkg::Z_LIMIT) begin
          mz_r <= -20'(twb_pkg::Z_LIMIT);
        end else if (zt < -twb_pkg::Z_LIMIT) begin
          mz_r <= 20'(twb_pkg::Z_LIMIT);
        end else begin
          mz_r <= -zt[19:0];
        end
      end
      twb_pkg::ST_DA:
        da_r <= twb_pkg::drive(twb_pkg::tshift(66'(mx_r) + (66'(mz_r) <<< 12), 12), LIM);
      twb_pkg::ST_B3: db_r <= twb_pkg::drive(twb_pkg::tshift(acc, 42), LIM);
      twb_pkg::ST_C3: dc_r <= twb_pkg::drive(twb_pkg::tshift(acc, 42), LIM);
      default: ;
    endcase
    if (load_out) begin
      oa_r <= da_r;
      ob_r <= db_r;
      oc_r <= dc_r;
    end
  end

endmodule

`default_nettype wire

/* verif/three_wheel_balance_controller_tb.sv */
`timescale 1ns / 1ps

module three_wheel_balance_controller_tb;

  localparam int PWM_LIM = 8300;
  localparam int IDLE_LIMIT = 20000;

  typedef struct {
    logic signed [14:0] roll;
    logic signed [14:0] pitch;
    logic signed [15:0] rr;
    logic signed [15:0] pr;
    logic signed [15:0] yr;
    logic signed [15:0] wa;
    logic signed [15:0] wb;
    logic signed [15:0] wc;
    logic               stop;
  } tick_t;

  typedef struct {
    logic signed [14:0] a;
    logic signed [14:0] b;
    logic signed [14:0] c;
  } drives_t;

  typedef struct {
    tick_t   t;
    bit      known;
    drives_t d;
  } row_t;

  logic clk;
  logic rst_n;
  twb_in_if  in_ch();
  twb_out_if out_ch();
  twb_cfg_if cfg_ch();

  three_wheel_balance_controller DUT (
    .clk(clk), .rst_n(rst_n), .in_item(in_ch), .out_item(out_ch), .cfg_wr(cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  logic signed [14:0] roll_tgt, pitch_tgt;
  longint gains[2:7];
  longint xf, xi, yf, yi, prev_yaw;
  drives_t drive_queue[$];
  int errors;
  int idle_cycles;
  bit out_stall_en;

  function automatic longint trunc_shift(longint v, int s);
    if (v < 0) return -((-v) >>> s);
    return v >>> s;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic logic signed [14:0] to_drive(longint v);
    return 15'(clip(clip(v, -PWM_LIM, PWM_LIM), -16384, 16383));
  endfunction

  function automatic longint speed_term(ref longint f, ref longint i, input longint s);
    longint nf;
    nf = clip(1229 * s + trunc_shift(2867 * f, 12), -64'sd2147483648, 64'sd2147483647);
    i = clip(i + nf, -27000 * 4096, 27000 * 4096);
    f = nf;
    return trunc_shift(nf * gains[2] + i * gains[3], 12);
  endfunction

  function automatic drives_t predict_drives(tick_t t);
    drives_t r;
    longint sxv, dd, sy, vx, vy, bx, by, z, mx, my, mz;
    if (t.stop) begin
      xf = 0; xi = 0; yf = 0; yi = 0;
      prev_yaw = t.yr;
      r.a = 0; r.b = 0; r.c = 0;
      return r;
    end
    sxv = 2 * longint'(t.wa) - t.wb - t.wc;
    dd = longint'(t.wb) - t.wc;
    sy = trunc_shift(dd * 64'sd1859775393, 30);
    vx = speed_term(xf, xi, sxv);
    vy = speed_term(yf, yi, sy);
    bx = trunc_shift((longint'(t.roll) - roll_tgt) * gains[4]
                     + 4 * longint'(t.rr) * gains[5], 6);
    by = trunc_shift((longint'(t.pitch) - pitch_tgt) * gains[4]
                     + 4 * longint'(t.pr) * gains[5], 6);
    dd = longint'(t.yr) - prev_yaw + longint'(twb_pkg::YAW_RATE_OFFSET_DEF);
    z = clip(trunc_shift(longint'(t.yr) * gains[6] + dd * gains[7], 16), -524287, 524287);
    prev_yaw = t.yr;
    mx = clip(vx - bx, -64'sd2147483648, 64'sd2147483647);
    my = clip(vy + by, -64'sd2147483648, 64'sd2147483647);
    mz = -z;
    r.a = to_drive(trunc_shift(mx + mz * 4096, 12));
    r.b = to_drive(trunc_shift(-mx * (64'sd1 << 29) + my * 64'sd929887697
                               + mz * (64'sd1 << 42), 42));
    r.c = to_drive(trunc_shift(-mx * (64'sd1 << 29) - my * 64'sd929887697
                               + mz * (64'sd1 << 42), 42));
    return r;
  endfunction

  task automatic write_reg(twb_pkg::reg_idx_t idx, logic [23:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    case (idx)
      twb_pkg::REG_ROLL_TARGET: roll_tgt = val[14:0];
      twb_pkg::REG_PITCH_TARGET: pitch_tgt = val[14:0];
      default: gains[int'(idx)] = val;
    endcase
    @(posedge clk);
  endtask

  task automatic write_ignored(logic [3:0] idx, logic [23:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain;
    while (drive_queue.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic send_tick(tick_t t, bit known, drives_t d);
    drives_t p;
    in_ch.valid <= 1'b1;
    in_ch.roll_angle <= t.roll;
    in_ch.pitch_angle <= t.pitch;
    in_ch.roll_rate <= t.rr;
    in_ch.pitch_rate <= t.pr;
    in_ch.yaw_rate <= t.yr;
    in_ch.wheel_count_a <= t.wa;
    in_ch.wheel_count_b <= t.wb;
    in_ch.wheel_count_c <= t.wc;
    in_ch.stop <= t.stop;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    p = predict_drives(t);
    drive_queue.push_back(known ? d : p);
  endtask

  function automatic logic signed [14:0] angle_val(int mode);
    case (mode)
      0: return -15'sd11520;
      1: return 15'sd11520;
      2: return $urandom_range(0, 1) ? 15'($urandom) : -15'sd16384;
      default: return 15'($urandom_range(0, 23040) - 11520);
    endcase
  endfunction

  function automatic tick_t random_tick(int kind);
    tick_t t;
    t.roll = angle_val($urandom_range(0, 9));
    t.pitch = angle_val($urandom_range(0, 9));
    t.rr = 16'($urandom);
    t.pr = 16'($urandom);
    t.yr = 16'($urandom);
    t.wa = 16'($urandom);
    t.wb = 16'($urandom);
    t.wc = 16'($urandom);
    if (kind == 0) begin
      t.roll = 15'($urandom_range(0, 80)) - 15'sd328;
      t.pitch = 15'($urandom_range(0, 80)) - 15'sd21;
      t.rr = 16'($urandom_range(0, 200)) - 16'sd100;
      t.pr = 16'($urandom_range(0, 200)) - 16'sd100;
      t.yr = 16'($urandom_range(0, 400)) - 16'sd200;
      t.wa = 16'($urandom_range(0, 60)) - 16'sd30;
      t.wb = 16'($urandom_range(0, 60)) - 16'sd30;
      t.wc = 16'($urandom_range(0, 60)) - 16'sd30;
    end
    t.stop = ($urandom_range(0, 19) == 0);
    return t;
  endfunction

  task automatic random_phase(int count);
    int burst;
    int sent;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && sent < count) begin
        send_tick(random_tick($urandom_range(0, 2)), 1'b0, '{default: 0});
        burst--;
        sent++;
      end
      if (sent < count && $urandom_range(0, 2) != 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
    end
    in_ch.valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= out_stall_en ? ($urandom_range(0, 3) != 0) : 1'b1;
    end
  end

  always @(posedge clk) begin
    drives_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (drive_queue.size() == 0) begin
        $error("drive item with nothing expected");
        errors++;
      end else begin
        e = drive_queue.pop_front();
        if (out_ch.drive_a !== e.a) begin
          $error("drive_a expected %0d actual %0d", e.a, out_ch.drive_a);
          errors++;
        end
        if (out_ch.drive_b !== e.b) begin
          $error("drive_b expected %0d actual %0d", e.b, out_ch.drive_b);
          errors++;
        end
        if (out_ch.drive_c !== e.c) begin
          $error("drive_c expected %0d actual %0d", e.c, out_ch.drive_c);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL three_wheel_balance_controller");
        $finish;
      end
    end
  end

  row_t table_rows[$];

  task automatic build_table;
    tick_t t;
    t = '{roll: -288, pitch: 19, rr: 0, pr: 0, yr: 0, wa: 0, wb: 0, wc: 0, stop: 0};
    table_rows.push_back('{t, 1'b1, '{0, 0, 0}});
    t.stop = 1; t.yr = 16'sh7FFF;
    table_rows.push_back('{t, 1'b1, '{0, 0, 0}});
    t = '{roll: 11520, pitch: 11520, rr: 16'sh7FFF, pr: 16'sh7FFF, yr: 16'sh7FFF,
          wa: 16'sh7FFF, wb: 16'sh7FFF, wc: 16'sh8000, stop: 0};
    table_rows.push_back('{t, 1'b0, '{0, 0, 0}});
    t = '{roll: -11520, pitch: -11520, rr: 16'sh8000, pr: 16'sh8000, yr: 16'sh8000,
          wa: 16'sh8000, wb: 16'sh8000, wc: 16'sh7FFF, stop: 0};
    table_rows.push_back('{t, 1'b0, '{0, 0, 0}});
    t = '{roll: 15'sh3FFF, pitch: -15'sd16384, rr: 16'sh8000, pr: 16'sh7FFF,
          yr: 16'sh8000, wa: 16'sh8000, wb: 16'sh7FFF, wc: 16'sh8000, stop: 0};
    table_rows.push_back('{t, 1'b0, '{0, 0, 0}});
    t = '{roll: 11520, pitch: -11520, rr: 16'sh7FFF, pr: 16'sh8000, yr: 16'sh7FFF,
          wa: 16'sh7FFF, wb: 16'sh8000, wc: 16'sh7FFF, stop: 1};
    table_rows.push_back('{t, 1'b1, '{0, 0, 0}});
    for (int k = 0; k < 6; k++) begin
      t = '{roll: 200, pitch: -100, rr: 16'(k * 50), pr: -16'sd40, yr: 16'(k * 300),
            wa: 16'(k * 7), wb: -16'sd3, wc: 16'sd5, stop: 0};
      table_rows.push_back('{t, 1'b0, '{0, 0, 0}});
    end
    t = '{roll: -288, pitch: 19, rr: 0, pr: 0, yr: 0, wa: 0, wb: 0, wc: 0, stop: 1};
    table_rows.push_back('{t, 1'b1, '{0, 0, 0}});
  endtask

  initial begin
    logic [23:0] v;
    errors = 0;
    out_stall_en = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.roll_angle = '0;
    in_ch.pitch_angle = '0;
    in_ch.roll_rate = '0;
    in_ch.pitch_rate = '0;
    in_ch.yaw_rate = '0;
    in_ch.wheel_count_a = '0;
    in_ch.wheel_count_b = '0;
    in_ch.wheel_count_c = '0;
    in_ch.stop = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    roll_tgt = -15'sd288;
    pitch_tgt = 15'sd19;
    gains[2] = 163840; gains[3] = 123; gains[4] = 3686400;
    gains[5] = 634880; gains[6] = 40960; gains[7] = 4096;
    xf = 0; xi = 0; yf = 0; yi = 0; prev_yaw = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    build_table();
    foreach (table_rows[k]) begin
      send_tick(table_rows[k].t, table_rows[k].known, table_rows[k].d);
      if (k % 3 == 1) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
    out_stall_en = 1'b1;
    random_phase(300);
    drain();

    write_reg(twb_pkg::REG_ROLL_TARGET, 24'(-15'sd11520));
    write_reg(twb_pkg::REG_PITCH_TARGET, 24'(15'sd11520));
    write_reg(twb_pkg::REG_SPEED_GAIN_P, 24'hFFFFFF);
    write_reg(twb_pkg::REG_SPEED_GAIN_I, 24'hFFFFFF);
    write_reg(twb_pkg::REG_TILT_GAIN_P, 24'hFFFFFF);
    write_reg(twb_pkg::REG_TILT_GAIN_D, 24'hFFFFFF);
    write_reg(twb_pkg::REG_SPIN_GAIN_P, 24'hFFFFFF);
    write_reg(twb_pkg::REG_SPIN_GAIN_D, 24'hFFFFFF);
    write_ignored(4'd9, 24'h123456);
    write_ignored(4'd15, 24'hFFFFFF);
    random_phase(250);
    drain();

    write_reg(twb_pkg::REG_ROLL_TARGET, 24'(15'sd11520));
    write_reg(twb_pkg::REG_PITCH_TARGET, 24'(-15'sd11520));
    for (int g = 2; g < 8; g++) write_reg(twb_pkg::reg_idx_t'(g), 24'h0);
    out_stall_en = 1'b0;
    random_phase(150);
    drain();

    for (int p = 0; p < 4; p++) begin
      out_stall_en = p[0];
      v = 24'($urandom);
      write_reg(twb_pkg::REG_ROLL_TARGET, 24'(15'($urandom_range(0, 23040) - 11520)));
      write_reg(twb_pkg::REG_PITCH_TARGET, 24'(15'($urandom_range(0, 23040) - 11520)));
      write_reg(twb_pkg::REG_SPEED_GAIN_P, 24'($urandom_range(0, 400000)));
      write_reg(twb_pkg::REG_SPEED_GAIN_I, 24'($urandom_range(0, 4000)));
      write_reg(twb_pkg::REG_TILT_GAIN_P, 24'($urandom_range(0, 24'hFFFFFF)));
      write_reg(twb_pkg::REG_TILT_GAIN_D, 24'($urandom_range(0, 2000000)));
      write_reg(twb_pkg::REG_SPIN_GAIN_P, v);
      write_reg(twb_pkg::REG_SPIN_GAIN_D, 24'($urandom));
      random_phase(160);
      drain();
    end

    if (errors == 0) begin
      $display("PASS three_wheel_balance_controller");
    end else begin
      $display("FAIL three_wheel_balance_controller");
    end
    $finish;
  end

endmodule

/* three_wheel_balance_controller.f */
rtl/twb_pkg.sv
rtl/twb_if.sv
rtl/twb_cfg.sv
rtl/twb_mac.sv
rtl/three_wheel_balance_controller.sv
verif/three_wheel_balance_controller_tb.sv
